// ===== hw/rtl/pip_pkg.sv =====
package pip_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int LEN_W      = 32;
    localparam int SUMSQ_W    = 2 * (COORD_W + 1) + 2;
    localparam int ROOT_W     = SUMSQ_W / 2;
    localparam int MUL_W      = LEN_W + 1;
    localparam int NUM_W      = LEN_W + 16;
    localparam int T_W        = 17;

    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_LAST    = 2'd1;
    localparam logic [1:0] ST_NO_PATH = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      closes_path;
        logic [15:0]               progress;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [1:0]                status;
    } t_out;

    function automatic logic signed [MUL_W-1:0] coord_diff(
        input logic [COORD_W-1:0] b,
        input logic [COORD_W-1:0] a
    );
        logic signed [MUL_W-1:0] eb;
        logic signed [MUL_W-1:0] ea;
        eb = $signed({{(MUL_W-COORD_W){b[COORD_W-1]}}, b});
        ea = $signed({{(MUL_W-COORD_W){a[COORD_W-1]}}, a});
        return eb - ea;
    endfunction

endpackage

// ===== hw/rtl/pip_sqrt.sv =====
module pip_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pip_pkg::SUMSQ_W-1:0] i_val,
    output logic                        o_done,
    output logic [pip_pkg::ROOT_W-1:0]  o_root
);
    import pip_pkg::*;

    logic [SUMSQ_W-1:0] r_val;
    logic [ROOT_W+2:0]  r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [$clog2(ROOT_W+1)-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [ROOT_W+2:0]  w_rem2;
    logic [ROOT_W+2:0]  w_trial;

    // two radicand bits per step, one root bit out
    assign w_rem2  = {r_rem[ROOT_W:0], r_val[SUMSQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[SUMSQ_W-3:0], 2'b00};
                if (w_rem2 >= w_trial) begin
                    r_rem  <= w_rem2 - w_trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == ($clog2(ROOT_W+1))'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/pip_div.sv =====
module pip_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pip_pkg::NUM_W-1:0] i_num,
    input  logic [pip_pkg::LEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [pip_pkg::T_W-1:0]   o_quot
);
    import pip_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [LEN_W-1:0] r_den;
    logic [LEN_W-1:0] r_rem;
    logic [$clog2(NUM_W+1)-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [LEN_W:0]   w_rem2;

    // restoring, one quotient bit per cycle
    assign w_rem2 = {r_rem, r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                if (w_rem2 >= {1'b0, r_den}) begin
                    r_rem <= LEN_W'(w_rem2 - {1'b0, r_den});
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[LEN_W-1:0];
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                if (r_cnt == ($clog2(NUM_W+1))'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[T_W-1:0];

endmodule

// ===== hw/rtl/polyline_position_interpolator.sv =====
// Channel   Direction  Beat marked by          Payload
// command   in         start & !busy           i_cmd  (pip_pkg::t_in)
// result    out        o_done, one cycle only  o_res  (pip_pkg::t_out)
//
// A load runs the squared deltas through the shared multiplier, then the 26-step
// bit-pair square root, takes the root, then writes the store. A dropped load
// (path full) writes nothing. A query on a short or zero-length path is answered
// straight from idle; else it walks the length memory segment by segment, then,
// for a segment of nonzero length, runs the 48-step divide and the lerp on the
// shared multiplier.
// Reset is synchronous and active low; it clears the point count and marks the
// path closed. The point and length memories are not cleared. The receiver
// cannot stall: each result beat is shown once, in the cycle after its final step.
module polyline_position_interpolator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pip_pkg::t_in  i_cmd,
    output logic          o_done,
    output pip_pkg::t_out o_res
);
    import pip_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LSQ  = 4'd1;
    localparam logic [3:0] S_LSR  = 4'd2;
    localparam logic [3:0] S_LFIN = 4'd3;
    localparam logic [3:0] S_QM   = 4'd4;
    localparam logic [3:0] S_QD   = 4'd5;
    localparam logic [3:0] S_QW   = 4'd6;
    localparam logic [3:0] S_QC   = 4'd7;
    localparam logic [3:0] S_QR1  = 4'd8;
    localparam logic [3:0] S_QR2  = 4'd9;
    localparam logic [3:0] S_QR3  = 4'd10;
    localparam logic [3:0] S_QDV  = 4'd11;
    localparam logic [3:0] S_QL   = 4'd12;

    // point and length stores
    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] mem_z [MAX_POINTS];
    logic [LEN_W-1:0]   mem_c [MAX_POINTS];

    logic [3:0]         r_state;
    logic [1:0]         r_step;
    logic [CNT_W-1:0]   r_count;
    logic               r_closed;
    t_in                r_in;
    logic [ADDR_W-1:0]  r_n;
    logic [ADDR_W-1:0]  r_i;
    logic [ADDR_W-1:0]  r_addr;
    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic [LEN_W-1:0]   r_cum_last;
    logic [SUMSQ_W-1:0] r_acc;
    logic signed [MUL_W-1:0]   r_ma, r_mb;
    logic signed [2*MUL_W-1:0] r_prod;
    logic [ROOT_W-1:0]  r_root;
    logic [LEN_W-1:0]   r_dist, r_lo, r_hi;
    logic [COORD_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [COORD_W-1:0] r_rd_x, r_rd_y, r_rd_z;
    logic [LEN_W-1:0]   r_rd_c;
    logic [T_W-1:0]     r_t;
    logic               r_done;
    t_out               r_out;

    logic               w_accept;
    logic [CNT_W-1:0]   w_eff;
    logic [LEN_W:0]     w_cum_sum;
    logic [LEN_W-1:0]   w_cum_new;
    logic [ADDR_W-1:0]  w_last;
    logic [T_W-1:0]     w_p;
    logic               w_sq_start, w_sq_done;
    logic [SUMSQ_W-1:0] w_sq_val;
    logic [ROOT_W-1:0]  w_sq_root;
    logic               w_dv_start, w_dv_done;
    logic [NUM_W-1:0]   w_dv_num;
    logic [LEN_W-1:0]   w_dv_den;
    logic [T_W-1:0]     w_dv_q;
    logic signed [2*MUL_W-1:0] w_shr;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign w_eff     = r_closed ? '0 : r_count;
    assign w_last    = ADDR_W'(r_count - 1'b1);
    assign w_p       = (i_cmd.progress == 16'hFFFF) ? T_W'(17'h10000)
                                                   : {1'b0, i_cmd.progress};
    assign w_cum_sum = {1'b0, r_cum_last} + (LEN_W+1)'(r_root);
    assign w_cum_new = (r_n == '0) ? '0 :
                       (w_cum_sum[LEN_W] ? {LEN_W{1'b1}} : w_cum_sum[LEN_W-1:0]);
    assign w_shr     = r_prod >>> 16;

    // fold the last square in on the way into the root unit
    assign w_sq_start = (r_state == S_LSQ) && (r_step == 2'd3);
    assign w_sq_val   = r_acc + r_prod[SUMSQ_W-1:0];

    assign w_dv_start = (r_state == S_QC) && (r_dist <= r_rd_c) && (r_rd_c != r_lo);
    assign w_dv_num   = {r_dist - r_lo, 16'h0000};
    assign w_dv_den   = r_rd_c - r_lo;

    pip_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_sq_val),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    pip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (w_dv_den),
        .o_done  (w_dv_done),
        .o_quot  (w_dv_q)
    );

    // the one shared multiplier: squares on loads, p*total and lerp on queries
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LFIN) begin
            mem_x[r_n] <= r_in.point_x;
            mem_y[r_n] <= r_in.point_y;
            mem_z[r_n] <= r_in.point_z;
            mem_c[r_n] <= w_cum_new;
        end
        r_rd_x <= mem_x[r_addr];
        r_rd_y <= mem_y[r_addr];
        r_rd_z <= mem_z[r_addr];
        r_rd_c <= mem_c[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_closed <= 1'b1;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in <= i_cmd;
                        if (i_cmd.kind == KIND_LOAD) begin
                            if (r_closed) begin
                                r_closed <= 1'b0;
                                r_count  <= '0;
                            end
                            if (w_eff < CNT_W'(MAX_POINTS)) begin
                                r_n <= ADDR_W'(w_eff);
                                if (w_eff == '0) begin
                                    r_state <= S_LFIN;
                                end else begin
                                    r_ma    <= coord_diff(i_cmd.point_x, r_px);
                                    r_mb    <= coord_diff(i_cmd.point_x, r_px);
                                    r_step  <= '0;
                                    r_state <= S_LSQ;
                                end
                            end else if (i_cmd.closes_path) begin
                                // path full: drop the point, keep the close
                                r_closed <= 1'b1;
                            end
                        end else if (r_count < CNT_W'(2)) begin
                            r_out  <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                                       status: ST_NO_PATH};
                            r_done <= 1'b1;
                        end else if (r_cum_last == '0) begin
                            r_out  <= '{pos_x: r_px, pos_y: r_py, pos_z: r_pz,
                                       status: ST_LAST};
                            r_done <= 1'b1;
                        end else begin
                            r_ma    <= MUL_W'(w_p);
                            r_mb    <= MUL_W'(r_cum_last);
                            r_state <= S_QM;
                        end
                    end
                end
                S_LSQ: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step)
                        2'd0: begin
                            r_ma <= coord_diff(r_in.point_y, r_py);
                            r_mb <= coord_diff(r_in.point_y, r_py);
                        end
                        2'd1: begin
                            r_acc <= r_prod[SUMSQ_W-1:0];
                            r_ma  <= coord_diff(r_in.point_z, r_pz);
                            r_mb  <= coord_diff(r_in.point_z, r_pz);
                        end
                        2'd2: r_acc   <= r_acc + r_prod[SUMSQ_W-1:0];
                        2'd3: r_state <= S_LSR;
                        default: r_state <= S_LSR;
                    endcase
                end
                S_LSR: begin
                    if (w_sq_done) begin
                        r_root  <= w_sq_root;
                        r_state <= S_LFIN;
                    end
                end
                S_LFIN: begin
                    r_count    <= CNT_W'(r_n) + 1'b1;
                    r_cum_last <= w_cum_new;
                    r_px       <= r_in.point_x;
                    r_py       <= r_in.point_y;
                    r_pz       <= r_in.point_z;
                    r_closed   <= r_in.closes_path;
                    r_state    <= S_IDLE;
                end
                S_QM: r_state <= S_QD;
                S_QD: begin
                    r_dist  <= r_prod[LEN_W+15:16];
                    r_i     <= ADDR_W'(1);
                    r_addr  <= ADDR_W'(1);
                    r_lo    <= '0;
                    r_state <= S_QW;
                end
                S_QW: r_state <= S_QC;
                S_QC: begin
                    if (r_dist <= r_rd_c) begin
                        // first segment that reaches the target distance
                        r_hi    <= r_rd_c;
                        r_addr  <= r_i - 1'b1;
                        r_state <= S_QR1;
                    end else if (r_i == w_last) begin
                        r_out   <= '{pos_x: r_px, pos_y: r_py, pos_z: r_pz,
                                    status: ST_LAST};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_lo    <= r_rd_c;
                        r_i     <= r_i + 1'b1;
                        r_addr  <= r_i + 1'b1;
                        r_state <= S_QW;
                    end
                end
                S_QR1: begin
                    r_addr  <= r_i;
                    r_state <= S_QR2;
                end
                S_QR2: begin
                    r_ax    <= r_rd_x;
                    r_ay    <= r_rd_y;
                    r_az    <= r_rd_z;
                    r_state <= S_QR3;
                end
                S_QR3: begin
                    r_bx <= r_rd_x;
                    r_by <= r_rd_y;
                    r_bz <= r_rd_z;
                    if (r_hi == r_lo) begin
                        // zero-length segment: give its start point
                        r_out   <= '{pos_x: r_ax, pos_y: r_ay, pos_z: r_az,
                                    status: ST_INSIDE};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_QDV;
                    end
                end
                S_QDV: begin
                    if (w_dv_done) begin
                        // load the x delta so its product is ready when the lerp writes pos_x
                        r_t     <= w_dv_q;
                        r_ma    <= coord_diff(r_bx, r_ax);
                        r_mb    <= MUL_W'(w_dv_q);
                        r_step  <= '0;
                        r_state <= S_QL;
                    end
                end
                S_QL: begin
                    r_step <= r_step + 1'b1;
                    r_mb   <= MUL_W'(r_t);
                    unique case (r_step)
                        2'd0: r_ma <= coord_diff(r_by, r_ay);
                        2'd1: begin
                            r_out.pos_x <= r_ax + w_shr[COORD_W-1:0];
                            r_ma        <= coord_diff(r_bz, r_az);
                        end
                        2'd2: begin
                            r_out.pos_y <= r_ay + w_shr[COORD_W-1:0];
                        end
                        2'd3: begin
                            r_out.pos_z  <= r_az + w_shr[COORD_W-1:0];
                            r_out.status <= ST_INSIDE;
                            r_done       <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_short_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.kind != KIND_LOAD && r_count < CNT_W'(2))
            |=> (o_done && o_res.status == ST_NO_PATH))
        else $error("short path query did not report no path");

    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_LSR))
        else $error("root finished outside its wait state");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_done |-> (r_state == S_QDV))
        else $error("divide finished outside its wait state");

endmodule

// ===== test/pip_checker.sv =====
`timescale 1ns / 100ps

// Watch the command and result channels of the interpolator, predict each query
// result from an own copy of the path memory, and compare in order.
module pip_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  pip_pkg::t_in   i_cmd,
    input  logic           i_done,
    input  pip_pkg::t_out  i_res,
    output int             o_errors,
    output int             o_pending,
    output int             o_results
);
    import pip_pkg::*;

    logic signed [COORD_W-1:0] path_x [MAX_POINTS];
    logic signed [COORD_W-1:0] path_y [MAX_POINTS];
    logic signed [COORD_W-1:0] path_z [MAX_POINTS];
    logic [LEN_W-1:0]          run_len [MAX_POINTS];
    int                        n_points;
    logic                      closed;
    t_out                      expected_pos [$];

    // Floor square root of a 64-bit value, one bit pair per step.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] delta_sq(input longint a, input longint b);
        longint      d;
        logic [63:0] m;
        d = a - b;
        m = (d < 0) ? -d : d;
        if (m >= 64'h1_0000_0000) return '1;
        return m * m;
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint t);
        longint p;
        p = (b - a) * t;
        return a + (p >>> 16);
    endfunction

    // Append one point (unless the path is full), or queue the position a query calls for.
    task automatic apply_cmd(input t_in c);
        logic [63:0] s;
        logic [63:0] acc;
        logic [63:0] total;
        logic [63:0] p;
        logic [63:0] target_dist;
        logic [63:0] lo;
        logic [63:0] t;
        t_out        r;
        int          last;
        bit          found;
        if (c.kind == KIND_LOAD) begin
            if (closed) begin
                n_points = 0;
                closed   = 1'b0;
            end
            if (n_points < MAX_POINTS) begin
                path_x[n_points] = c.point_x;
                path_y[n_points] = c.point_y;
                path_z[n_points] = c.point_z;
                if (n_points == 0) begin
                    run_len[0] = 0;
                end else begin
                    s = delta_sq(c.point_x, path_x[n_points-1]);
                    s = sum_sat(s, delta_sq(c.point_y, path_y[n_points-1]));
                    s = sum_sat(s, delta_sq(c.point_z, path_z[n_points-1]));
                    acc = 64'(run_len[n_points-1]) + floor_sqrt(s);
                    run_len[n_points] = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
                end
                n_points++;
            end
            if (c.closes_path) closed = 1'b1;
            return;
        end
        if (n_points < 2) begin
            r = '{pos_x: '0, pos_y: '0, pos_z: '0, status: ST_NO_PATH};
            expected_pos.push_back(r);
            return;
        end
        last  = n_points - 1;
        total = run_len[last];
        r = '{pos_x: path_x[last], pos_y: path_y[last], pos_z: path_z[last],
              status: ST_LAST};
        if (total != 0) begin
            p           = (c.progress == 16'hFFFF) ? 64'h1_0000 : 64'(c.progress);
            target_dist = (p * total) >> 16;
            found       = 1'b0;
            for (int i = 1; i <= last && !found; i++) begin
                if (target_dist <= run_len[i]) begin
                    found = 1'b1;
                    lo = run_len[i-1];
                    r.status = ST_INSIDE;
                    if (run_len[i] == lo || target_dist < lo) begin
                        r.pos_x = path_x[i-1];
                        r.pos_y = path_y[i-1];
                        r.pos_z = path_z[i-1];
                    end else begin
                        t = ((target_dist - lo) << 16) / (run_len[i] - lo);
                        r.pos_x = COORD_W'(lerp(path_x[i-1], path_x[i], t));
                        r.pos_y = COORD_W'(lerp(path_y[i-1], path_y[i], t));
                        r.pos_z = COORD_W'(lerp(path_z[i-1], path_z[i], t));
                    end
                end
            end
        end
        expected_pos.push_back(r);
    endtask

    always_ff @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            n_points    = 0;
            closed      = 1'b1;
            expected_pos.delete();
            o_errors   <= 0;
            o_results  <= 0;
        end else begin
            if (i_start && !i_busy) apply_cmd(i_cmd);
            if (i_done) begin
                o_results <= o_results + 1;
                if (expected_pos.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_pos.pop_front();
                    if (i_res !== want) begin
                        $display({"%0t: mismatch expected x=%0d y=%0d z=%0d st=%0d,",
                                  " got x=%0d y=%0d z=%0d st=%0d"},
                                 $time, want.pos_x, want.pos_y, want.pos_z, want.status,
                                 i_res.pos_x, i_res.pos_y, i_res.pos_z, i_res.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_pos.size();
    end

endmodule

// ===== test/tb_polyline_position_interpolator.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict; the checker beside the block does all prediction.
module tb_polyline_position_interpolator;
    import pip_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_cmd;
    logic o_done;
    t_out o_res;
    int   n_errors;
    int   n_pending;
    int   n_results;
    int   n_loads;
    int   n_queries;

    polyline_position_interpolator uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_cmd  (i_cmd),
        .o_done (o_done),
        .o_res  (o_res)
    );

    pip_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_cmd    (i_cmd),
        .i_done   (o_done),
        .i_res    (o_res),
        .o_errors (n_errors),
        .o_pending(n_pending),
        .o_results(n_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop, sized for about 1100 beats plus their gaps.
    initial begin
        #20ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    // Coordinate draw: mostly modest values, sometimes full range or extremes.
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            1, 2:    return COORD_W'($urandom);
            default: return 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [15:0] rand_progress();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one beat after a random gap, hold it until accepted, then drop start.
    task automatic send_beat(input t_in c);
        repeat ($urandom_range(0, 9)) @(posedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        if (c.kind == KIND_LOAD) n_loads++;
        else n_queries++;
    endtask

    task automatic load_pt(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic last);
        t_in c;
        c = '{kind: KIND_LOAD, point_x: x, point_y: y, point_z: z,
              closes_path: last, progress: 16'($urandom)};
        send_beat(c);
    endtask

    task automatic query_at(input logic [15:0] p);
        t_in c;
        c = '{kind: KIND_QUERY, point_x: COORD_W'($urandom),
              point_y: COORD_W'($urandom), point_z: COORD_W'($urandom),
              closes_path: 1'($urandom), progress: p};
        send_beat(c);
    endtask

    initial begin
        int pts;
        start   = 1'b0;
        i_cmd   = '0;
        i_rst_n = 1'b0;
        n_loads = 0;
        n_queries = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no path, single point, zero total, zero-length segment, extremes.
        query_at(16'h8000);
        load_pt(24'd16, 24'd32, 24'd48, 1'b0);
        query_at(16'h4000);
        load_pt(24'd16, 24'd32, 24'd48, 1'b0);
        query_at(16'h8000);
        load_pt(24'd160, 24'd32, 24'd48, 1'b0);
        load_pt(24'd160, 24'd32, 24'd48, 1'b0);
        load_pt(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
        load_pt(24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
        query_at(16'h0000);
        query_at(16'h0001);
        query_at(16'h8000);
        query_at(16'hFFFE);
        query_at(16'hFFFF);
        // Hold until the block has drained everything.
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        // Overfill past capacity; closes_path on a dropped point still ends the path.
        for (int i = 0; i < MAX_POINTS + 3; i++)
            load_pt(24'(i * 37), 24'(-i * 11), 24'(i & 7), i == MAX_POINTS + 2);
        query_at(16'hFFFF);
        query_at(16'h1234);

        // Random: mostly short paths with random content, queries mid-path and after close.
        while (n_loads + n_queries < 1050) begin
            pts = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                               : $urandom_range(1, 8);
            for (int i = 0; i < pts; i++) begin
                load_pt(rand_coord(), rand_coord(), rand_coord(), i == pts - 1);
                if ($urandom_range(0, 5) == 0) query_at(rand_progress());
            end
            repeat ($urandom_range(1, 6)) query_at(rand_progress());
        end

        while (n_pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d loads and %0d queries; %0d position beats checked.",
                 n_loads, n_queries, n_results);
        if (n_errors == 0 && n_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
